@@ rtl/positional_list_store_top_assert.svh @@
// Assertion macros for the positional list store.
// Included by positional_list_store_top; relies on nothing else.
`ifndef POSITIONAL_LIST_STORE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_STORE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PLS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define PLS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define PLS_ASSERT_SAME(label, clk, rstn, ante, cons)
`define PLS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/pls_pkg.sv @@
// Shared types, constants and helpers for the positional list store.
// Used by pls_ctrl, pls_dpath and positional_list_store_top; no dependencies.
`default_nettype none

package pls_pkg;

    localparam int CAPACITY    = 16;
    localparam int MAX_RESULTS = 16;

    localparam int MODE_W = 2;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DUMP_W = $clog2(((CAPACITY > MAX_RESULTS) ? CAPACITY : MAX_RESULTS) + 1);

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] item;
        logic [LEN_W-1:0]        length;
        logic                    last;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic op_load;
        logic dump_start;
        logic dump_step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic dump_req;
        logic dump_final;
    } stat_t;

    // The length field shows the count modulo its field width.
    function automatic logic [LEN_W-1:0] to_len(input logic [CNT_W-1:0] cnt);
        return LEN_W'(cnt);
    endfunction

endpackage

`default_nettype wire

@@ rtl/pls_ctrl.sv @@
// Controller for the positional list store: idle and dump states.
// Depends on pls_pkg for the command and status structs.
`default_nettype none

module pls_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire pls_pkg::stat_t stat,
    output pls_pkg::cmd_t       cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        cmd.op_load    = 1'b0;
        cmd.dump_start = 1'b0;
        cmd.dump_step  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = stat.out_free;
                if (s_valid && stat.out_free) begin
                    if (stat.dump_req) begin
                        cmd.dump_start = 1'b1;
                        state_next     = ST_DUMP;
                    end else begin
                        cmd.op_load = 1'b1;
                    end
                end
            end
            ST_DUMP: begin
                // One entry per cycle whenever the output register can take it.
                if (stat.out_free) begin
                    cmd.dump_step = 1'b1;
                    if (stat.dump_final) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pls_dpath.sv @@
// Datapath for the positional list store: entry cells, count, dump index
// and the output register. Depends on pls_pkg.
`default_nettype none

module pls_dpath (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire pls_pkg::in_t  s_data,
    output pls_pkg::out_t      m_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire pls_pkg::cmd_t cmd,
    output pls_pkg::stat_t     stat
);

    logic signed [pls_pkg::VAL_W-1:0] cells_reg  [pls_pkg::CAPACITY];
    logic signed [pls_pkg::VAL_W-1:0] cells_next [pls_pkg::CAPACITY];
    logic [pls_pkg::CNT_W-1:0]        count_reg;
    logic [pls_pkg::CNT_W-1:0]        count_next;
    logic [pls_pkg::IDX_W-1:0]        idx_reg;
    logic                             out_valid_reg;
    pls_pkg::out_t                    out_reg;
    logic [pls_pkg::STAT_W-1:0]       op_status;
    logic [pls_pkg::CMP_W-1:0]        pos_x;
    logic [pls_pkg::CMP_W-1:0]        cnt_x;
    logic [pls_pkg::DUMP_W-1:0]       step_n;

    assign pos_x  = pls_pkg::CMP_W'(s_data.position);
    assign cnt_x  = pls_pkg::CMP_W'(count_reg);
    assign step_n = pls_pkg::DUMP_W'(idx_reg) + pls_pkg::DUMP_W'(1);

    // Insert and remove shift each cell past the position from its neighbour, all in parallel.
    always_comb begin
        cells_next = cells_reg;
        count_next = count_reg;
        op_status  = pls_pkg::ST_OK;
        unique case (s_data.mode)
            pls_pkg::MODE_INSERT: begin
                if (pos_x > cnt_x) begin
                    op_status = pls_pkg::ST_BADPOS;
                end else if (count_reg == pls_pkg::CNT_W'(pls_pkg::CAPACITY)) begin
                    op_status = pls_pkg::ST_FULL;
                end else begin
                    for (int i = 1; i < pls_pkg::CAPACITY; i++) begin
                        if (pls_pkg::CMP_W'(i) > pos_x) begin
                            cells_next[i] = cells_reg[i-1];
                        end
                    end
                    for (int i = 0; i < pls_pkg::CAPACITY; i++) begin
                        if (pls_pkg::CMP_W'(i) == pos_x) begin
                            cells_next[i] = s_data.value;
                        end
                    end
                    count_next = count_reg + pls_pkg::CNT_W'(1);
                end
            end
            pls_pkg::MODE_REMOVE: begin
                if (count_reg == '0) begin
                    op_status = pls_pkg::ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    op_status = pls_pkg::ST_BADPOS;
                end else begin
                    for (int i = 0; i < pls_pkg::CAPACITY - 1; i++) begin
                        if (pls_pkg::CMP_W'(i) >= pos_x) begin
                            cells_next[i] = cells_reg[i+1];
                        end
                    end
                    count_next = count_reg - pls_pkg::CNT_W'(1);
                end
            end
            pls_pkg::MODE_DUMP: begin
                // Only an empty list reaches here as a single-result operation.
                op_status = pls_pkg::ST_EMPTY;
            end
            default: begin
                op_status = pls_pkg::ST_BADPOS;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.op_load) begin
            cells_reg <= cells_next;
        end
        if (cmd.dump_start) begin
            idx_reg <= '0;
        end else if (cmd.dump_step) begin
            idx_reg <= idx_reg + pls_pkg::IDX_W'(1);
        end
        if (cmd.op_load) begin
            out_reg.status <= op_status;
            out_reg.item   <= '0;
            out_reg.length <= pls_pkg::to_len(count_next);
            out_reg.last   <= 1'b1;
        end else if (cmd.dump_step) begin
            out_reg.status <= pls_pkg::ST_OK;
            out_reg.item   <= cells_reg[idx_reg];
            out_reg.length <= pls_pkg::to_len(count_reg);
            out_reg.last   <= stat.dump_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.op_load) begin
                count_reg <= count_next;
            end
            if (cmd.op_load || cmd.dump_step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free   = !out_valid_reg || m_ready;
    assign stat.dump_req   = (s_data.mode == pls_pkg::MODE_DUMP) && (count_reg != '0);
    assign stat.dump_final = (step_n == pls_pkg::DUMP_W'(count_reg))
                          || (step_n == pls_pkg::DUMP_W'(pls_pkg::MAX_RESULTS));

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

@@ rtl/positional_list_store_top.sv @@
// Positional list store: top level joining pls_ctrl and pls_dpath (uses pls_pkg).
// Insert, remove and invalid operations: result registered in the cycle after the
// transfer; a new item can be taken every cycle while m_ready keeps the output free.
// Dump: the controller enters its dump state at the transfer, then loads one entry per
// cycle while the output is free; the input waits for min(count, MAX_RESULTS) entries.
// Synchronous active-low reset empties the list; entry cells are not cleared.
`default_nettype none

module positional_list_store_top (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire pls_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output pls_pkg::out_t      m_data
);

    pls_pkg::cmd_t  cmd;
    pls_pkg::stat_t stat;

    pls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pls_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

`include "positional_list_store_top_assert.svh"

    // Only dump results may leave the last flag low, and they are always ok.
    `PLS_ASSERT_SAME(a_mid_ok, aclk, aresetn, m_valid && !m_data.last, m_data.status == pls_pkg::ST_OK)
    // A single-result operation always presents its result in the next cycle.
    `PLS_ASSERT_NEXT(a_op_gives_result, aclk, aresetn, cmd.op_load, m_valid)
    // Once a dump starts, no other operation is executed in the following cycle.
    `PLS_ASSERT_NEXT(a_dump_blocks_input, aclk, aresetn, cmd.dump_start, !cmd.op_load && !s_ready)

endmodule

`default_nettype wire
